>>> rtl/core/dcbd_pkg.sv
// shared constants and the month table for the date day-count pipeline
package dcbd_pkg;

	// field widths
	localparam int YEAR_BITS  = 14;
	localparam int MONTH_BITS = 4;
	localparam int DAY_BITS   = 5;
	localparam int DIFF_BITS  = 22;

	// year plus a rounding offset needs one more bit
	localparam int SUM_BITS = YEAR_BITS + 1;

	// day number: 365 * year plus small terms stays below 2**(YEAR_BITS + 9)
	localparam int DAY_NUM_BITS = YEAR_BITS + 9;

	// days before a month: at most 365, plus a day of up to 31
	localparam int CUM_BITS = 9;
	localparam int MD_BITS  = 10;

	// division by 100 through a reciprocal multiply, exact for x < 2**SUM_BITS
	localparam int RECIP_SHIFT = SUM_BITS + 7;
	localparam int RECIP_100   = ((2 ** RECIP_SHIFT) + 99) / 100;
	localparam int RECIP_BITS  = $clog2(RECIP_100 + 1);
	localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
	localparam int QUO_BITS    = SUM_BITS - 6;
	localparam int REM_BITS    = 7;

	localparam logic [DIFF_BITS-1:0] DIFF_MAX = {DIFF_BITS{1'b1}};

	// first month that follows february
	localparam logic [MONTH_BITS-1:0] MONTH_MARCH = MONTH_BITS'(3);

	// days of all earlier months in a common year
	function automatic logic [CUM_BITS-1:0] cum_days(input logic [MONTH_BITS-1:0] m);
		logic [CUM_BITS-1:0] r;
		case (m)
			4'd0, 4'd1: r = 9'd0;
			4'd2:       r = 9'd31;
			4'd3:       r = 9'd59;
			4'd4:       r = 9'd90;
			4'd5:       r = 9'd120;
			4'd6:       r = 9'd151;
			4'd7:       r = 9'd181;
			4'd8:       r = 9'd212;
			4'd9:       r = 9'd243;
			4'd10:      r = 9'd273;
			4'd11:      r = 9'd304;
			4'd12:      r = 9'd334;
			default:    r = 9'd365;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/day_count_between_dates.sv
// days between two gregorian dates, four register stages
// each date pair passes the three day-number stages, then the difference stage, to the output
// throughput: one date pair per cycle; the whole pipeline holds while the
// output is stalled, so item_stall follows result_stall when the output is full
// reset: arst_n clears all valid bits asynchronously; data registers are not reset
module day_count_between_dates (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [dcbd_pkg::YEAR_BITS-1:0]    first_year,
	input  logic [dcbd_pkg::MONTH_BITS-1:0]   first_month,
	input  logic [dcbd_pkg::DAY_BITS-1:0]     first_day,
	input  logic [dcbd_pkg::YEAR_BITS-1:0]    second_year,
	input  logic [dcbd_pkg::MONTH_BITS-1:0]   second_month,
	input  logic [dcbd_pkg::DAY_BITS-1:0]     second_day,
	input  logic                              count_last_day,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [dcbd_pkg::DIFF_BITS-1:0]    day_difference,
	output logic                              order_error
);

	localparam int NB = dcbd_pkg::DAY_NUM_BITS;
	localparam int DB = dcbd_pkg::DIFF_BITS;

	logic en;
	logic earlier;
	logic [NB-1:0] num_a, num_b, num_b_plus, diff;
	logic v_s1, v_s2, v_s3, v_s4;
	logic err_s1, err_s2, err_s3, err_s4;
	logic plus_s1, plus_s2, plus_s3;
	logic [DB-1:0] diff_s4;

	// pipeline advances unless the output beat is held
	assign en         = !(v_s4 && result_stall);
	assign item_stall = !en;

	// order test on the raw fields, year then month then day
	assign earlier = {second_year, second_month, second_day} <
		{first_year, first_month, first_day};

	dcbd_day_num u_first (
		.clk     (clk),
		.en      (en),
		.year    (first_year),
		.month   (first_month),
		.day     (first_day),
		.day_num (num_a)
	);

	dcbd_day_num u_second (
		.clk     (clk),
		.en      (en),
		.year    (second_year),
		.month   (second_month),
		.day     (second_day),
		.day_num (num_b)
	);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// side data alongside the day-number stages
	always_ff @(posedge clk) begin
		if (en) begin
			err_s1  <= earlier;
			plus_s1 <= count_last_day;
			err_s2  <= err_s1;
			plus_s2 <= plus_s1;
			err_s3  <= err_s2;
			plus_s3 <= plus_s2;
		end
	end

	// difference, forced to zero on an order error, with clamping at zero and at the field maximum
	assign num_b_plus = num_b + NB'(plus_s3);
	assign diff       = num_b_plus - num_a;

	always_ff @(posedge clk) begin
		if (en) begin
			err_s4 <= err_s3;
			if (err_s3 || (num_b_plus <= num_a)) begin
				diff_s4 <= '0;
			end else if (diff > NB'(dcbd_pkg::DIFF_MAX)) begin
				diff_s4 <= dcbd_pkg::DIFF_MAX;
			end else begin
				diff_s4 <= diff[DB-1:0];
			end
		end
	end

	assign result_valid   = v_s4;
	assign day_difference = diff_s4;
	assign order_error    = err_s4;

endmodule

>>> rtl/core/dcbd_day_num.sv
// three-stage pipeline turning a year, month and day into a day number
module dcbd_day_num (
	input  logic                                clk,
	input  logic                                en,
	input  logic [dcbd_pkg::YEAR_BITS-1:0]      year,
	input  logic [dcbd_pkg::MONTH_BITS-1:0]     month,
	input  logic [dcbd_pkg::DAY_BITS-1:0]       day,
	output logic [dcbd_pkg::DAY_NUM_BITS-1:0]   day_num
);

	localparam int YB = dcbd_pkg::YEAR_BITS;
	localparam int SB = dcbd_pkg::SUM_BITS;
	localparam int PB = dcbd_pkg::PROD_BITS;
	localparam int QB = dcbd_pkg::QUO_BITS;
	localparam int NB = dcbd_pkg::DAY_NUM_BITS;
	localparam int K  = dcbd_pkg::RECIP_SHIFT;
	localparam logic [PB-1:0] RECIP = PB'(dcbd_pkg::RECIP_100);

	// stage 1 operands
	logic [SB-1:0] y99, y399q;
	logic [YB-1:0] y_s1;
	logic [PB-1:0] p_cent_s1, p_quad_s1, p_year_s1;
	logic [dcbd_pkg::MD_BITS-1:0] md_s1;
	logic late_s1;

	// stage 2 signals
	logic [QB-1:0] q_cent, q_quad, q_year;
	logic [QB+6:0] q_year_x100;
	logic [dcbd_pkg::REM_BITS-1:0] rem100;
	logic [SB-1:0] y3;
	logic [NB-1:0] yr365_s2;
	logic [SB-3:0] quarter_s2;
	logic [QB-1:0] q_cent_s2, q_quad_s2;
	logic [dcbd_pkg::MD_BITS-1:0] md_s2;
	logic leap_add_s2;

	logic [NB-1:0] day_num_s3;

	assign y99   = SB'(year) + SB'(99);
	assign y399q = (SB'(year) + SB'(399)) >> 2;

	// reciprocal products for the century terms, month offset plus day, and the march-or-later flag
	always_ff @(posedge clk) begin
		if (en) begin
			y_s1      <= year;
			p_cent_s1 <= PB'(y99) * RECIP;
			p_quad_s1 <= PB'(y399q) * RECIP;
			p_year_s1 <= PB'(year) * RECIP;
			md_s1     <= dcbd_pkg::MD_BITS'(dcbd_pkg::cum_days(month)) +
				dcbd_pkg::MD_BITS'(day);
			late_s1   <= (month >= dcbd_pkg::MONTH_MARCH);
		end
	end

	// quotients, remainder by 100 and the leap test
	assign q_cent      = p_cent_s1[K +: QB];
	assign q_quad      = p_quad_s1[K +: QB];
	assign q_year      = p_year_s1[K +: QB];
	assign q_year_x100 = (QB+7)'(q_year) * (QB+7)'(100);
	assign rem100      = dcbd_pkg::REM_BITS'(SB'(y_s1) - SB'(q_year_x100));
	assign y3          = SB'(y_s1) + SB'(3);

	always_ff @(posedge clk) begin
		if (en) begin
			yr365_s2    <= NB'(y_s1) * NB'(365);
			quarter_s2  <= y3[SB-1:2];
			q_cent_s2   <= q_cent;
			q_quad_s2   <= q_quad;
			md_s2       <= md_s1;
			leap_add_s2 <= late_s1 &&
				(((y_s1[1:0] == 2'b00) && (rem100 != '0)) ||
				((rem100 == '0) && (q_year[1:0] == 2'b00)));
		end
	end

	// final sum of the day number
	always_ff @(posedge clk) begin
		if (en) begin
			day_num_s3 <= yr365_s2 + NB'(quarter_s2) - NB'(q_cent_s2) + NB'(q_quad_s2) +
				NB'(md_s2) + NB'(leap_add_s2);
		end
	end

	assign day_num = day_num_s3;

endmodule
